>>> design/egh_pkg.sv
// ----------------------------------------------------------------------------
// egh_pkg: shared types and constants of the effect gate
// Field widths, register map, gate and operator codes.
// ----------------------------------------------------------------------------
package egh_pkg;

	localparam int RULE_SLOTS   = 4;
	localparam int TIME_W       = 64;
	localparam int VALUE_W      = 32;
	localparam int MS_W         = 16;
	// 65535 ms * 1000 fits in 26 bits
	localparam int US_SPAN_W    = 26;
	localparam int US_PER_MS    = 1000;
	localparam int OP_W         = 3;
	localparam int RULE_CNT_W   = 3;
	localparam int APB_DATA_W   = 64;
	localparam int APB_ADDR_W   = 6;

	typedef enum logic [0:0] {
		ITEM_EVAL  = 1'b0,
		ITEM_TELEM = 1'b1
	} item_mode_t;

	typedef enum logic [1:0] {
		GATE_ALWAYS = 2'd0,
		GATE_IDLE   = 2'd1,
		GATE_COND   = 2'd2,
		GATE_UNUSED = 2'd3
	} gate_mode_t;

	typedef enum logic [OP_W-1:0] {
		OP_EQ = 3'd0,
		OP_NE = 3'd1,
		OP_LT = 3'd2,
		OP_LE = 3'd3,
		OP_GT = 3'd4,
		OP_GE = 3'd5
	} rule_op_t;

	typedef enum logic [2:0] {
		REG_GATE_MODE  = 3'd0,
		REG_HOLD_MS    = 3'd1,
		REG_IDLE_MS    = 3'd2,
		REG_RULE_COUNT = 3'd3,
		REG_RULE_OPS   = 3'd4,
		REG_RULE_LO    = 3'd5,
		REG_RULE_HI    = 3'd6
	} reg_idx_t;

	// Signed Q16.16 compare; unknown operator codes never hold.
	function automatic logic rule_holds(logic [OP_W-1:0] op,
			logic signed [VALUE_W-1:0] a, logic signed [VALUE_W-1:0] b);
		logic hit;
		hit = 1'b0;
		case (op)
			OP_EQ:   hit = (a == b);
			OP_NE:   hit = (a != b);
			OP_LT:   hit = (a < b);
			OP_LE:   hit = (a <= b);
			OP_GT:   hit = (a > b);
			OP_GE:   hit = (a >= b);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

>>> design/egh_item_if.sv
// ----------------------------------------------------------------------------
// egh_item_if: input channel of the effect gate
// Valid/ready channel carrying one evaluate or telemetry word.
// ----------------------------------------------------------------------------
interface egh_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic [egh_pkg::TIME_W-1:0]            now_us;
	logic                                  watched_valid;
	logic signed [egh_pkg::VALUE_W-1:0]    probe_value;

	modport source (output valid, mode, now_us, watched_valid, probe_value,
		input ready);
	modport sink (input valid, mode, now_us, watched_valid, probe_value,
		output ready);
endinterface

>>> design/egh_result_if.sv
// ----------------------------------------------------------------------------
// egh_result_if: result channel of the effect gate
// Valid/ready channel carrying the gate decision word.
// ----------------------------------------------------------------------------
interface egh_result_if;
	logic                       valid;
	logic                       ready;
	logic                       active;
	logic [egh_pkg::TIME_W-1:0] hold_start_us;

	modport source (output valid, active, hold_start_us, input ready);
	modport sink (input valid, active, hold_start_us, output ready);
endinterface

>>> design/effect_gate_with_hold.sv
// ----------------------------------------------------------------------------
// effect_gate_with_hold: LED effect gate with hold window
// Decides per evaluate word whether the effect is painted; telemetry words
// only record their arrival time.
// ----------------------------------------------------------------------------
//  port       | dir | kind          | words
//  item       | in  | valid/ready   | evaluate (one result) or telemetry (none)
//  result     | out | valid/ready   | active, hold_start_us
//  psel..     | in  | APB           | registers at 8*index, 64-bit data
//
// From accept to result a word passes input stage _s1, then the result register.
// One word per cycle sustained unless stalled; the state update (hold, start,
// telemetry time) sits in the single step from _s1 to the result register.
// A telemetry word leaves _s1 without touching the result register.
// The input stalls only while _s1 holds an evaluate word and the result
// register is full and not taken. Reset clears control state and registers.
// ----------------------------------------------------------------------------
module effect_gate_with_hold (
	input  logic                              clk,
	input  logic                              arst_n,
	egh_item_if.sink                          item,
	egh_result_if.source                      result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [egh_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [egh_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [egh_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int TW = egh_pkg::TIME_W;
	localparam int SW = egh_pkg::US_SPAN_W;

	// configuration
	logic [1:0]                         gate_mode_q;
	logic [egh_pkg::MS_W-1:0]           hold_ms_q;
	logic [egh_pkg::MS_W-1:0]           idle_ms_q;
	logic [egh_pkg::US_SPAN_W-1:0]      hold_us_q;
	logic [egh_pkg::US_SPAN_W-1:0]      idle_us_q;
	logic [egh_pkg::RULE_CNT_W-1:0]     rule_count_q;
	logic [egh_pkg::RULE_SLOTS*egh_pkg::OP_W-1:0] rule_ops_q;
	logic [63:0]                        rule_lo_q;
	logic [63:0]                        rule_hi_q;
	logic [127:0]                       rule_vals;
	logic                               cfg_wr;
	logic [2:0]                         cfg_idx;

	// input stage
	logic                               valid_s1;
	logic                               mode_s1;
	logic [TW-1:0]                      now_s1;
	logic [TW-1:0]                      deadline_s1;
	logic                               cond_hit_s1;
	logic                               cond_hit;

	// gate state
	logic                               holding_q;
	logic [TW-1:0]                      start_q;
	logic [TW-1:0]                      deadline_q;
	logic [TW-1:0]                      last_tel_q;

	// result register
	logic                               out_valid_q;
	logic                               active_q;
	logic [TW-1:0]                      started_q;

	logic                               fire_s1;
	logic                               eval_fire;
	logic                               tel_fire;
	logic                               idle_hit;
	logic                               matched;
	logic                               in_window;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[5:3];
	assign cfg_wr  = psel & penable & pwrite;
	assign rule_vals = {rule_hi_q, rule_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_mode_q  <= '0;
			hold_ms_q    <= '0;
			idle_ms_q    <= '0;
			hold_us_q    <= '0;
			idle_us_q    <= '0;
			rule_count_q <= '0;
			rule_ops_q   <= '0;
			rule_lo_q    <= '0;
			rule_hi_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				egh_pkg::REG_GATE_MODE:  gate_mode_q <= pwdata[1:0];
				egh_pkg::REG_HOLD_MS: begin
					hold_ms_q <= pwdata[15:0];
					hold_us_q <= SW'(pwdata[15:0]) * SW'(egh_pkg::US_PER_MS);
				end
				egh_pkg::REG_IDLE_MS: begin
					idle_ms_q <= pwdata[15:0];
					idle_us_q <= SW'(pwdata[15:0]) * SW'(egh_pkg::US_PER_MS);
				end
				egh_pkg::REG_RULE_COUNT: rule_count_q <= pwdata[2:0];
				egh_pkg::REG_RULE_OPS:   rule_ops_q   <= pwdata[11:0];
				egh_pkg::REG_RULE_LO:    rule_lo_q    <= pwdata;
				egh_pkg::REG_RULE_HI:    rule_hi_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			egh_pkg::REG_GATE_MODE:  prdata = 64'(gate_mode_q);
			egh_pkg::REG_HOLD_MS:    prdata = 64'(hold_ms_q);
			egh_pkg::REG_IDLE_MS:    prdata = 64'(idle_ms_q);
			egh_pkg::REG_RULE_COUNT: prdata = 64'(rule_count_q);
			egh_pkg::REG_RULE_OPS:   prdata = 64'(rule_ops_q);
			egh_pkg::REG_RULE_LO:    prdata = rule_lo_q;
			egh_pkg::REG_RULE_HI:    prdata = rule_hi_q;
			default:                 prdata = '0;
		endcase
	end

	// ---------------- rule compare, ahead of the input register ----------------
	always_comb begin
		cond_hit = 1'b0;
		for (int r = 0; r < egh_pkg::RULE_SLOTS; r++) begin
			// rule_count above the slot count enables every slot
			if (4'(r) < 4'(rule_count_q) &&
					egh_pkg::rule_holds(rule_ops_q[r*egh_pkg::OP_W +: egh_pkg::OP_W],
						item.probe_value, $signed(rule_vals[r*egh_pkg::VALUE_W +:
						egh_pkg::VALUE_W])))
				cond_hit = 1'b1;
		end
		cond_hit = cond_hit & item.watched_valid;
	end

	// ---------------- handshake ----------------
	assign fire_s1   = valid_s1 &
		((mode_s1 == egh_pkg::ITEM_TELEM) | ~out_valid_q | result.ready);
	assign eval_fire = fire_s1 & (mode_s1 == egh_pkg::ITEM_EVAL);
	assign tel_fire  = fire_s1 & (mode_s1 == egh_pkg::ITEM_TELEM);
	assign item.ready = ~valid_s1 | fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_s1     <= egh_pkg::ITEM_EVAL;
			now_s1      <= '0;
			deadline_s1 <= '0;
			cond_hit_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
			if (item.valid) begin
				mode_s1     <= item.mode;
				now_s1      <= item.now_us;
				deadline_s1 <= item.now_us + TW'(hold_us_q);
				cond_hit_s1 <= cond_hit;
			end
		end
	end

	// ---------------- gate decision ----------------
	// last telemetry time zero means none seen yet
	assign idle_hit = (last_tel_q == '0) ||
		((now_s1 > last_tel_q) && ((now_s1 - last_tel_q) > TW'(idle_us_q)));

	always_comb begin
		unique case (gate_mode_q)
			egh_pkg::GATE_IDLE: matched = idle_hit;
			egh_pkg::GATE_COND: matched = cond_hit_s1;
			default:            matched = 1'b1;
		endcase
	end

	assign in_window = holding_q & (now_s1 < deadline_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q   <= 1'b0;
			start_q     <= '0;
			deadline_q  <= '0;
			last_tel_q  <= '0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			started_q   <= '0;
		end else begin
			if (tel_fire)
				last_tel_q <= now_s1;
			if (eval_fire) begin
				out_valid_q <= 1'b1;
				priority if (matched) begin
					if (!holding_q) begin
						holding_q <= 1'b1;
						start_q   <= now_s1;
						started_q <= now_s1;
					end else begin
						started_q <= start_q;
					end
					deadline_q <= deadline_s1;
					active_q   <= 1'b1;
				end else if (in_window) begin
					active_q  <= 1'b1;
					started_q <= start_q;
				end else begin
					holding_q <= 1'b0;
					active_q  <= 1'b0;
					started_q <= '0;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.active        = active_q;
	assign result.hold_start_us = started_q;

	// ---------------- assertions ----------------
	a_match_holds: assert property (@(posedge clk) disable iff (!arst_n)
		eval_fire && matched |=> holding_q && out_valid_q && active_q)
		else $error("match did not open hold");

	a_idle_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !active_q |-> started_q == '0)
		else $error("inactive word with nonzero start");

	a_tel_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		tel_fire && out_valid_q && result.ready |=> !out_valid_q)
		else $error("telemetry word produced a result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |-> !item.ready)
		else $error("input taken while stage stalled");

	a_start_kept: assert property (@(posedge clk) disable iff (!arst_n)
		eval_fire && holding_q && (matched || in_window) |=> $stable(start_q))
		else $error("start time moved during hold");

endmodule
